>>> rtl/core/line_substring_filter_macros.svh
// Assertion macros shared by the line filter RTL.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef LINE_SUBSTRING_FILTER_MACROS_SVH
`define LINE_SUBSTRING_FILTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LSF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("line_substring_filter: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("line_substring_filter: next-cycle check failed");

`endif

>>> rtl/core/lsf_pkg.sv
// Shared types and constants of the line substring filter.
// Used by lsf_cfg_regs, lsf_line_match and line_substring_filter.
package lsf_pkg;

    localparam int unsigned CFG_INDEX_WIDTH     = 3;
    localparam int unsigned CFG_DATA_WIDTH      = 64;
    localparam int unsigned PATTERN_STORE_BYTES = 16;
    localparam int unsigned LINE_NUM_WIDTH      = 32;
    localparam int unsigned FILE_INDEX_WIDTH    = 8;
    localparam logic [7:0]  NEWLINE_BYTE        = 8'd10;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_HIGH = 3'd1,
        CFG_PATTERN_LEN  = 3'd2,
        CFG_INVERT       = 3'd3,
        CFG_COUNT_ONLY   = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [8*PATTERN_STORE_BYTES-1:0] pattern;
        logic [4:0]                       pattern_length;
        logic                             invert_select;
        logic                             count_only;
    } t_cfg;

    // Control for one byte leaving the input register.
    typedef struct packed {
        logic step;
        logic take;
        logic line_end;
    } t_step_ctl;

endpackage

>>> rtl/core/lsf_cfg_regs.sv
// Configuration register file of the line substring filter.
// Depends on lsf_pkg for the register indexes and the t_cfg bundle.
module lsf_cfg_regs
    import lsf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PATTERN_LOW:  r_cfg.pattern[63:0]   <= i_cfg_data;
                CFG_PATTERN_HIGH: r_cfg.pattern[127:64] <= i_cfg_data;
                CFG_PATTERN_LEN:  r_cfg.pattern_length  <= i_cfg_data[4:0];
                CFG_INVERT:       r_cfg.invert_select   <= i_cfg_data[0];
                CFG_COUNT_ONLY:   r_cfg.count_only      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

>>> rtl/core/lsf_line_match.sv
// Sliding byte window and parallel pattern compare for the current line.
// Depends on lsf_pkg for t_cfg and t_step_ctl.
module lsf_line_match
    import lsf_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_step_ctl i_ctl,
    input  logic [7:0] i_byte,
    output logic      o_hit
);

    localparam int unsigned LW = $clog2(PATTERN_MAX + 1);

    logic [7:0]    r_win   [PATTERN_MAX];
    logic [7:0]    n_win   [PATTERN_MAX];
    logic [7:0]    p_byte  [PATTERN_MAX];
    logic [LW-1:0] r_cnt;
    logic [LW-1:0] n_cnt;
    logic          r_hit;
    logic          n_hit;
    logic [LW-1:0] len_used;
    logic [PATTERN_MAX:0] match_len;
    logic          match_now;

    // Newest byte sits at position 0; the window only holds bytes of this line
    // up to the byte count, so stale entries never take part in a compare.
    assign n_win[0] = i_byte;

    for (genvar i = 1; i < PATTERN_MAX; i++) begin : g_shift
        assign n_win[i] = r_win[i-1];
    end

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pbyte
        if (k < PATTERN_STORE_BYTES) begin : g_stored
            assign p_byte[k] = i_cfg.pattern[8*k +: 8];
        end else begin : g_zero
            assign p_byte[k] = 8'd0;
        end
    end

    // One AND-reduced compare per possible pattern length.
    assign match_len[0] = 1'b0;
    for (genvar l = 1; l <= PATTERN_MAX; l++) begin : g_len
        logic [l-1:0] eq;
        for (genvar k = 0; k < l; k++) begin : g_cmp
            assign eq[k] = (p_byte[k] == n_win[l-1-k]);
        end
        assign match_len[l] = &eq;
    end

    always_comb begin
        if (32'(i_cfg.pattern_length) > PATTERN_MAX) begin
            len_used = LW'(PATTERN_MAX);
        end else begin
            len_used = LW'(i_cfg.pattern_length);
        end
        if (32'(r_cnt) < PATTERN_MAX) begin
            n_cnt = r_cnt + 1'b1;
        end else begin
            n_cnt = r_cnt;
        end
        match_now = i_ctl.take && (len_used != '0) && (n_cnt >= len_used)
                    && match_len[len_used];
        n_hit     = r_hit | match_now;
        o_hit     = n_hit | (len_used == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && i_ctl.take) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_hit <= 1'b0;
        end else if (i_ctl.step) begin
            if (i_ctl.line_end) begin
                r_cnt <= '0;
                r_hit <= 1'b0;
            end else if (i_ctl.take) begin
                r_cnt <= n_cnt;
                r_hit <= n_hit;
            end
        end
    end

endmodule

>>> rtl/core/line_substring_filter.sv
// Top level of the line substring filter: input register, line and file
// counters, result register. Depends on lsf_pkg, lsf_cfg_regs, lsf_line_match
// and line_substring_filter_macros.svh.
//
// The block takes one text byte per clock and keeps taking bytes while a
// result waits in the output register, stalling only when a byte that produces
// a result meets a full, unaccepted result. A byte passes through the input
// register, and its result, if any, is loaded from there into the result
// register. Outside such stalls the sustained rate of one byte per cycle is
// set by the update of the byte window, its parallel compare against every
// pattern length, and the counters. Configuration writes are taken in every
// cycle and act from the next byte processed.
`include "line_substring_filter_macros.svh"

module line_substring_filter
    import lsf_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = 16,
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_file_end,
    input  logic                         i_stream_end,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_line_selected,
    output logic [LINE_NUM_WIDTH-1:0]    o_line_num,
    output logic [FILE_INDEX_WIDTH-1:0]  o_file_index,
    output logic [LINE_NUM_WIDTH-1:0]    o_selected_total,
    output logic                         o_is_total
);

    localparam int unsigned CW = (COUNT_WIDTH < LINE_NUM_WIDTH) ?
                                 COUNT_WIDTH : LINE_NUM_WIDTH;

    t_cfg      cfg;
    t_step_ctl ctl;
    logic      hit;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_fend;
    logic        r_in_send;

    logic [CW-1:0]               r_cur_line;
    logic [CW-1:0]               r_total;
    logic [FILE_INDEX_WIDTH-1:0] r_cur_file;
    logic [CW-1:0]               n_total;

    logic                         r_out_valid;
    logic                         r_out_selected;
    logic [LINE_NUM_WIDTH-1:0]    r_out_line;
    logic [FILE_INDEX_WIDTH-1:0]  r_out_file;
    logic [LINE_NUM_WIDTH-1:0]    r_out_total;
    logic                         r_out_is_total;

    logic fend;
    logic line_end;
    logic emit;
    logic advance;
    logic sel;

    lsf_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lsf_line_match #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_line_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_ctl   (ctl),
        .i_byte  (r_in_byte),
        .o_hit   (hit)
    );

    always_comb begin
        fend     = r_in_fend | r_in_send;
        line_end = (r_in_byte == NEWLINE_BYTE) | fend;
        emit     = line_end && (!cfg.count_only || r_in_send);
        // A byte that gives no result never waits on the output side.
        advance  = r_in_valid && (!emit || !r_out_valid || i_out_ready);
        ctl.step     = advance;
        ctl.take     = (r_in_byte != NEWLINE_BYTE);
        ctl.line_end = line_end;
        sel      = hit ^ cfg.invert_select;
        if (sel && (r_total != '1)) begin
            n_total = r_total + 1'b1;
        end else begin
            n_total = r_total;
        end
    end

    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_fend <= i_file_end;
            r_in_send <= i_stream_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_line <= CW'(1);
            r_total    <= '0;
            r_cur_file <= '0;
        end else if (advance && line_end) begin
            if (fend) begin
                r_cur_line <= CW'(1);
            end else if (r_cur_line != '1) begin
                r_cur_line <= r_cur_line + 1'b1;
            end
            if (r_in_send) begin
                r_cur_file <= '0;
                r_total    <= '0;
            end else begin
                r_total <= n_total;
                if (fend && (r_cur_file != '1)) begin
                    r_cur_file <= r_cur_file + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_total    <= LINE_NUM_WIDTH'(n_total);
            r_out_is_total <= cfg.count_only;
            if (cfg.count_only) begin
                r_out_selected <= 1'b0;
                r_out_line     <= '0;
                r_out_file     <= '0;
            end else begin
                r_out_selected <= sel;
                r_out_line     <= LINE_NUM_WIDTH'(r_cur_line);
                r_out_file     <= r_cur_file;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_line_selected  = r_out_selected;
    assign o_line_num       = r_out_line;
    assign o_file_index     = r_out_file;
    assign o_selected_total = r_out_total;
    assign o_is_total       = r_out_is_total;

    // The total result carries no line position.
    `LSF_ASSERT_NOW(a_total_fields_zero, r_out_valid && r_out_is_total, !r_out_selected && (r_out_line == '0) && (r_out_file == '0))
    // Line numbers are one-based and never wrap to zero.
    `LSF_ASSERT_NOW(a_line_never_zero, 1'b1, r_cur_line != '0)
    // Stream end returns the position and total counters to their start values.
    `LSF_ASSERT_NEXT(a_stream_end_restart, advance && r_in_send, (r_cur_line == CW'(1)) && (r_cur_file == '0) && (r_total == '0))
    // A byte that produces a result always lands in the result register.
    `LSF_ASSERT_NEXT(a_emit_loads_result, advance && emit, r_out_valid)

endmodule

>>> sim/tb_line_substring_filter.sv
// Self-checking testbench for line_substring_filter: directed lines, then random
// text with planted patterns under random configurations and random stalls.
// Depends on lsf_pkg and the line_substring_filter RTL.
`timescale 1ns / 100ps

module tb_line_substring_filter;
    import lsf_pkg::*;

    localparam int unsigned ITEM_TARGET   = 1850;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned WINDOW_BYTES  = 16;

    // Tracks the line and file state of the filter and holds the line
    // verdicts that have been computed but not yet seen on the output.
    class line_tally;
        typedef struct {
            logic        selected;
            logic [31:0] line_no;
            logic [7:0]  file_no;
            logic [31:0] total;
            logic        is_total;
        } t_verdict;

        t_verdict     awaited_lines[$];
        int unsigned  errors;
        logic [127:0] pattern;
        logic [4:0]   pattern_len;
        logic         invert;
        logic         only_total;
        logic [7:0]   window[WINDOW_BYTES];
        int unsigned  line_fill;
        logic         line_hit;
        logic [31:0]  line_no;
        logic [31:0]  total;
        logic [7:0]   file_no;

        function new();
            errors      = 0;
            pattern     = '0;
            pattern_len = '0;
            invert      = 1'b0;
            only_total  = 1'b0;
            line_no     = 32'd1;
            total       = '0;
            file_no     = '0;
            clear_line();
        endfunction

        function void clear_line();
            foreach (window[k]) window[k] = 8'h00;
            line_fill = 0;
            line_hit  = 1'b0;
        endfunction

        function void set_register(t_cfg_index idx, logic [63:0] value);
            case (idx)
                CFG_PATTERN_LOW:  pattern[63:0]   = value;
                CFG_PATTERN_HIGH: pattern[127:64] = value;
                CFG_PATTERN_LEN:  pattern_len     = value[4:0];
                CFG_INVERT:       invert          = value[0];
                CFG_COUNT_ONLY:   only_total      = value[0];
                default: ;
            endcase
        endfunction

        function void take_byte(logic [7:0] value, logic last_of_file, logic last_of_stream);
            int unsigned len;
            logic        same;
            logic        hit;
            logic        selected;
            logic        ends_file;
            t_verdict    v;
            len       = (pattern_len > WINDOW_BYTES) ? WINDOW_BYTES : pattern_len;
            ends_file = last_of_file || last_of_stream;
            if (value != NEWLINE_BYTE) begin
                for (int k = WINDOW_BYTES - 1; k > 0; k--) window[k] = window[k-1];
                window[0] = value;
                if (line_fill < WINDOW_BYTES) line_fill++;
                if (len != 0 && line_fill >= len) begin
                    same = 1'b1;
                    for (int k = 0; k < len; k++)
                        if (pattern[8*k +: 8] != window[len-1-k]) same = 1'b0;
                    if (same) line_hit = 1'b1;
                end
            end
            if (value == NEWLINE_BYTE || ends_file) begin
                hit      = line_hit || (len == 0);
                selected = hit ^ invert;
                if (selected && total != '1) total++;
                if (!only_total) begin
                    v = '{selected, line_no, file_no, total, 1'b0};
                    awaited_lines.push_back(v);
                end else if (last_of_stream) begin
                    v = '{1'b0, 32'd0, 8'd0, total, 1'b1};
                    awaited_lines.push_back(v);
                end
                clear_line();
                if (line_no != '1) line_no++;
                if (ends_file) begin
                    line_no = 32'd1;
                    if (file_no != 8'hFF) file_no++;
                end
                if (last_of_stream) begin
                    file_no = '0;
                    total   = '0;
                end
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_line(logic selected, logic [31:0] number, logic [7:0] file,
                                 logic [31:0] count, logic marks_total);
            t_verdict v;
            if (awaited_lines.size() == 0) begin
                $display("%0t: unexpected result, expected none actual line %0d file %0d",
                         $time, number, file);
                errors++;
                return;
            end
            v = awaited_lines.pop_front();
            compare_field("line_selected", 32'(v.selected), 32'(selected));
            compare_field("line_num", v.line_no, number);
            compare_field("file_index", 32'(v.file_no), 32'(file));
            compare_field("selected_total", v.total, count);
            compare_field("is_total", 32'(v.is_total), 32'(marks_total));
        endfunction

        function int unsigned awaited();
            return awaited_lines.size();
        endfunction

        function void report_leftovers();
            if (awaited_lines.size() != 0) begin
                $display("%0t: %0d results expected but never received", $time,
                         awaited_lines.size());
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]    i_cfg_data = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic [7:0]                   i_data_byte = '0;
    logic                         i_file_end = 1'b0;
    logic                         i_stream_end = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic                         o_line_selected;
    logic [LINE_NUM_WIDTH-1:0]    o_line_num;
    logic [FILE_INDEX_WIDTH-1:0]  o_file_index;
    logic [LINE_NUM_WIDTH-1:0]    o_selected_total;
    logic                         o_is_total;

    line_tally   board;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned ready_hold = 0;
    bit          steady_flow = 1'b0;

    line_substring_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_file_end      (i_file_end),
        .i_stream_end    (i_stream_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_line_selected (o_line_selected),
        .o_line_num      (o_line_num),
        .o_file_index    (o_file_index),
        .o_selected_total(o_selected_total),
        .o_is_total      (o_is_total)
    );

    always #1 i_clk = ~i_clk;

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A result is checked before the byte of the same edge is noted, since that
    // byte cannot have produced it.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                board.match_line(o_line_selected, o_line_num, o_file_index,
                                 o_selected_total, o_is_total);
            if (i_cfg_valid && o_cfg_ready)
                board.set_register(t_cfg_index'(i_cfg_index), i_cfg_data);
            if (i_in_valid && o_in_ready)
                board.take_byte(i_data_byte, i_file_end, i_stream_end);
        end
    end

    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (steady_flow || $urandom_range(0, 99) < 65) begin
            i_out_ready <= 1'b1;
            ready_hold  <= $urandom_range(0, 10);
        end else begin
            i_out_ready <= 1'b0;
            ready_hold  <= idle_len();
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_line_substring_filter: errors");
        $finish;
    end

    // Leaves the write valid high so that back-to-back writes need no toggle.
    task automatic write_register(t_cfg_index idx, logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic configure(logic [127:0] pat, logic [4:0] len, logic inv, logic only_total);
        write_register(CFG_PATTERN_LOW, pat[63:0]);
        write_register(CFG_PATTERN_HIGH, pat[127:64]);
        write_register(CFG_PATTERN_LEN, 64'(len));
        write_register(CFG_INVERT, 64'(inv));
        write_register(CFG_COUNT_ONLY, 64'(only_total));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_byte(logic [7:0] value, logic last_of_file, logic last_of_stream);
        int unsigned gap;
        gap = steady_flow ? 0 : idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= value;
        i_file_end   <= last_of_file;
        i_stream_end <= last_of_stream;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // A byte that ends no line leaves nothing to wait for, so a further settling
    // wait lets it clear the input register before the next write.
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.awaited() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] text_byte(logic [127:0] pat, int unsigned used);
        if (used != 0 && $urandom_range(0, 99) < 60)
            return pat[8*$urandom_range(0, used - 1) +: 8];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_line(logic [127:0] pat, int unsigned used,
                                    bit ends_file, bit ends_stream);
        logic [7:0]  text[$];
        int unsigned n_pre;
        int unsigned n_post;
        int unsigned spoil;
        int unsigned kind;
        logic        fe;
        n_pre  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 6);
        n_post = $urandom_range(0, 6);
        kind   = $urandom_range(0, 9);
        for (int k = 0; k < n_pre; k++) text.push_back(text_byte(pat, used));
        // Plant the whole pattern, or a copy with one byte spoiled.
        if (used != 0 && kind < 7) begin
            spoil = (kind < 5) ? used : $urandom_range(0, used - 1);
            for (int k = 0; k < used; k++)
                text.push_back((k == spoil) ? ~pat[8*k +: 8] : pat[8*k +: 8]);
        end
        for (int k = 0; k < n_post; k++) text.push_back(text_byte(pat, used));
        if (!ends_file || text.size() == 0 || $urandom_range(0, 1) == 1)
            text.push_back(NEWLINE_BYTE);
        // At stream end the file end flag may be left off.
        fe = ends_stream ? 1'($urandom_range(0, 1)) : ends_file;
        foreach (text[i]) begin
            if (i == text.size() - 1)
                send_byte(text[i], fe, ends_stream);
            else
                send_byte(text[i], 1'b0, 1'b0);
        end
    endtask

    task automatic random_phase();
        logic [127:0] pat;
        logic [4:0]   len;
        logic         only_total;
        int unsigned  used;
        int unsigned  files;
        int unsigned  lines;
        int unsigned  pick;
        bit           ends_stream;
        steady_flow = ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            pat = '0;
        else if (pick == 1)
            pat = '1;
        else
            pat = {$urandom, $urandom, $urandom, $urandom};
        pick = $urandom_range(0, 19);
        if (pick == 0)
            len = 5'd0;
        else if (pick < 3)
            len = 5'd16;
        else if (pick == 3)
            len = 5'($urandom_range(17, 31));
        else
            len = 5'($urandom_range(1, 6));
        only_total = ($urandom_range(0, 3) == 0);
        configure(pat, len, 1'($urandom_range(0, 1)), only_total);
        used        = (len > WINDOW_BYTES) ? WINDOW_BYTES : len;
        ends_stream = only_total || ($urandom_range(0, 9) < 6);
        files       = $urandom_range(1, 3);
        for (int f = 0; f < files; f++) begin
            lines = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (int l = 0; l < lines; l++)
                send_random_line(pat, used, l == lines - 1,
                                 ends_stream && f == files - 1 && l == lines - 1);
        end
        wait_quiet();
    endtask

    // Enough one-byte files to drive the file index into saturation.
    task automatic file_index_run();
        steady_flow = ($urandom_range(0, 1) == 1);
        configure({$urandom, $urandom, $urandom, $urandom}, 5'd1, 1'($urandom_range(0, 1)),
                  1'b0);
        for (int i = 0; i < 270; i++) send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        wait_quiet();
    endtask

    initial begin
        bit saturated;
        saturated = 1'b0;
        board = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Two-byte pattern: a hit, an empty line, a pattern split over two
        // lines, a file ending on a plain byte, and a stream end without file end.
        configure(128'h6261, 5'd2, 1'b0, 1'b0);
        send_byte("x", 1'b0, 1'b0);
        send_byte("a", 1'b0, 1'b0);
        send_byte("b", 1'b0, 1'b0);
        send_byte(NEWLINE_BYTE, 1'b0, 1'b0);
        send_byte(NEWLINE_BYTE, 1'b0, 1'b0);
        send_byte("a", 1'b0, 1'b0);
        send_byte(NEWLINE_BYTE, 1'b0, 1'b0);
        send_byte("b", 1'b0, 1'b0);
        send_byte(NEWLINE_BYTE, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte("a", 1'b0, 1'b0);
        send_byte("b", 1'b0, 1'b1);
        wait_quiet();

        // Empty pattern matches everything, so inverted nothing is selected.
        configure('0, 5'd0, 1'b1, 1'b0);
        send_byte(NEWLINE_BYTE, 1'b1, 1'b0);
        send_byte("q", 1'b0, 1'b0);
        send_byte(NEWLINE_BYTE, 1'b0, 1'b1);
        wait_quiet();

        // Count-only with a zero-byte pattern; one total at stream end.
        configure('0, 5'd1, 1'b1, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(NEWLINE_BYTE, 1'b0, 1'b0);
        send_byte("z", 1'b1, 1'b0);
        send_byte(NEWLINE_BYTE, 1'b1, 1'b1);
        wait_quiet();

        while (bytes_sent < ITEM_TARGET) begin
            if (!saturated && bytes_sent > 800) begin
                file_index_run();
                saturated = 1'b1;
            end else begin
                random_phase();
            end
        end
        steady_flow = 1'b0;
        wait_quiet();

        board.report_leftovers();
        if (board.errors == 0)
            $display("tb_line_substring_filter: clean");
        else
            $display("tb_line_substring_filter: errors");
        $finish;
    end

endmodule
